>>> hdl/three_class_priority_queue_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the three-class priority queue unit
// Concurrent checks on a rising clock with synchronous reset disable.
// ---------------------------------------------------------------------------
`ifndef THREE_CLASS_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define THREE_CLASS_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TPQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/tpq_pkg.sv
// ---------------------------------------------------------------------------
// Three-class priority queue package
// Sizes, status codes and the decision record shared by the unit's modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CLASS_COUNT = 3;

   localparam int TAG_W   = 64;
   localparam int CLASS_W = 2;
   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W  = $clog2(CLASS_COUNT * QUEUE_DEPTH);

   localparam logic [FILL_W-1:0]  FILL_MAX  = FILL_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(QUEUE_DEPTH - 1);

   localparam logic [CLASS_W-1:0] CLASS_HIGH    = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_MID     = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_LOW     = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd3;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_SERVE   = 1'b1
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_ENQUEUED = 3'd0,
      ST_SERVED   = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_FULL     = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   // Outcome of one request: result fields plus the tag store access.
   typedef struct packed {
      status_type          status;
      logic [CLASS_W-1:0]  served_class;
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } decision_type;

   // First slot of a class inside the shared tag store.
   function automatic logic [ADDR_W-1:0] class_base(input logic [CLASS_W-1:0] cls);
      logic [ADDR_W-1:0] base;
      base = '0;
      case (cls)
         CLASS_HIGH: base = '0;
         CLASS_MID:  base = ADDR_W'(QUEUE_DEPTH);
         CLASS_LOW:  base = ADDR_W'(2 * QUEUE_DEPTH);
         default:    base = '0;
      endcase
      return base;
   endfunction

   // Step a ring index, wrapping at the queue depth.
   function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
   endfunction

endpackage

>>> hdl/tpq_ctrl.sv
// ---------------------------------------------------------------------------
// Queue control
// Holds head, tail and fill of each class; decides each request in one pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic                         req_type,
   input  logic [tpq_pkg::CLASS_W-1:0]  req_service_class,
   output tpq_pkg::decision_type        decision
);
   import tpq_pkg::*;

   `include "three_class_priority_queue_unit_assert.svh"

   logic [IDX_W-1:0]  rd_idx_ff   [CLASS_COUNT];
   logic [IDX_W-1:0]  rd_idx_in   [CLASS_COUNT];
   logic [IDX_W-1:0]  wr_idx_ff   [CLASS_COUNT];
   logic [IDX_W-1:0]  wr_idx_in   [CLASS_COUNT];
   logic [FILL_W-1:0] fill_ff     [CLASS_COUNT];
   logic [FILL_W-1:0] fill_in     [CLASS_COUNT];

   logic               is_serve;
   logic [CLASS_W-1:0] sel_class;
   logic               any_held;

   assign is_serve = (req_type == REQ_SERVE);

   // Strict priority pick: lowest numbered class that holds anyone.
   always_comb begin
      any_held  = 1'b1;
      sel_class = CLASS_HIGH;
      if (fill_ff[0] != '0) begin
         sel_class = CLASS_HIGH;
      end else if (fill_ff[1] != '0) begin
         sel_class = CLASS_MID;
      end else if (fill_ff[2] != '0) begin
         sel_class = CLASS_LOW;
      end else begin
         any_held = 1'b0;
      end
   end

   always_comb begin
      decision              = '0;
      decision.status       = ST_EMPTY;
      decision.wr_addr      = class_base(req_service_class);
      decision.rd_addr      = class_base(sel_class);
      rd_idx_in             = rd_idx_ff;
      wr_idx_in             = wr_idx_ff;
      fill_in               = fill_ff;
      if (!is_serve) begin
         if (req_service_class == CLASS_INVALID) begin
            decision.status = ST_INVALID;
         end else if (fill_ff[req_service_class] == FILL_MAX) begin
            decision.status = ST_FULL;
         end else begin
            decision.status  = ST_ENQUEUED;
            decision.wr_en   = accept;
            decision.wr_addr = class_base(req_service_class)
                             + ADDR_W'(wr_idx_ff[req_service_class]);
            wr_idx_in[req_service_class] = advance(wr_idx_ff[req_service_class]);
            fill_in[req_service_class]   = fill_ff[req_service_class] + FILL_W'(1);
         end
      end else if (any_held) begin
         decision.status       = ST_SERVED;
         decision.served_class = sel_class;
         decision.rd_en        = accept;
         decision.rd_addr      = class_base(sel_class) + ADDR_W'(rd_idx_ff[sel_class]);
         rd_idx_in[sel_class]  = advance(rd_idx_ff[sel_class]);
         fill_in[sel_class]    = fill_ff[sel_class] - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '{default: '0};
         wr_idx_ff <= '{default: '0};
         fill_ff   <= '{default: '0};
      end else if (accept) begin
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         fill_ff   <= fill_in;
      end
   end

   `TPQ_ASSERT_NEXT(a_idle_holds_fill, clock, reset, !accept,
      $stable(fill_ff[0]) && $stable(fill_ff[1]) && $stable(fill_ff[2]),
      "fill moved without a request")
   `TPQ_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1,
      (fill_ff[0] <= FILL_MAX) && (fill_ff[1] <= FILL_MAX) && (fill_ff[2] <= FILL_MAX),
      "fill beyond queue depth")
   `TPQ_ASSERT_NOW(a_strict_priority, clock, reset, decision.status == ST_SERVED,
      (fill_ff[decision.served_class] != '0)
      && ((decision.served_class == CLASS_HIGH) || (fill_ff[0] == '0))
      && ((decision.served_class != CLASS_LOW) || (fill_ff[1] == '0)),
      "serve skipped a higher class")

endmodule

>>> hdl/tpq_tag_store.sv
// ---------------------------------------------------------------------------
// Tag store
// Shared memory of customer tags for all classes, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpq_tag_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [tpq_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [tpq_pkg::TAG_W-1:0]   wr_data,
   input  logic                        rd_en,
   input  logic [tpq_pkg::ADDR_W-1:0]  rd_addr,
   output logic [tpq_pkg::TAG_W-1:0]   rd_data
);
   import tpq_pkg::*;

   localparam int ENTRIES = CLASS_COUNT * QUEUE_DEPTH;

   logic [TAG_W-1:0] mem [ENTRIES];
   logic [TAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Write and read never share a cycle, so no bypass is needed.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/three_class_priority_queue_unit.sv
// ---------------------------------------------------------------------------
// Three-class priority queue unit
// Three FIFO queues of customer tags served under strict class priority.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_type, req_service_class and req_customer_tag
//   and raise start; a request is taken at each rising edge with start high
//   and busy low. busy stays low, so one request can be taken every cycle.
//   Enqueue (req_type 0) appends the tag to the tail of the named class;
//   serve (req_type 1) pops the head of class 0, else 1, else 2.
//   Result channel: every request yields exactly one result, shown on the
//   rsp_ ports for one cycle with rsp_strobe high, in the cycle right after
//   the request was taken (throughput 1 request per cycle).
//   The receiver cannot stall; it must take the result in that cycle.
//   The rate is set by the decision pass over the class pointers
//   and the single write or registered read of the shared tag store.
//   Reset (synchronous, active high) empties all classes and drops any
//   result in flight; the tag store is not cleared, and only slots that
//   hold a queued customer are ever read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module three_class_priority_queue_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_type,
   input  logic [tpq_pkg::CLASS_W-1:0]  req_service_class,
   input  logic [tpq_pkg::TAG_W-1:0]    req_customer_tag,
   output logic                         rsp_strobe,
   output logic [2:0]                   rsp_status,
   output logic [tpq_pkg::TAG_W-1:0]    rsp_served_tag,
   output logic [tpq_pkg::CLASS_W-1:0]  rsp_served_class
);
   import tpq_pkg::*;

   `include "three_class_priority_queue_unit_assert.svh"

   logic               accept;
   decision_type       decision;
   logic [TAG_W-1:0]   store_rd_data;

   // Result register.
   logic               strobe_ff;
   status_type         status_ff;
   logic [CLASS_W-1:0] class_ff;

   // Never hold off a request: every one finishes in a single pass.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Decide the request against the current head, tail and fill.
   tpq_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .req_type          (req_type),
      .req_service_class (req_service_class),
      .decision          (decision)
   );

   // Store an enqueued tag, or fetch the tag being served.
   tpq_tag_store u_tag_store (
      .clock   (clock),
      .wr_en   (decision.wr_en),
      .wr_addr (decision.wr_addr),
      .wr_data (req_customer_tag),
      .rd_en   (decision.rd_en),
      .rd_addr (decision.rd_addr),
      .rd_data (store_rd_data)
   );

   // Raise the strobe for exactly one cycle after each taken request.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
   end

   // Capture the result fields alongside the tag store read.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= decision.status;
         class_ff  <= decision.served_class;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_served_class = class_ff;
   // Zero the tag on every result that is not a serve.
   assign rsp_served_tag   = (status_ff == ST_SERVED) ? store_rd_data : '0;

   `TPQ_ASSERT_NEXT(a_result_follows_request, clock, reset, accept, rsp_strobe, "request produced no result")
   `TPQ_ASSERT_NEXT(a_no_spurious_result, clock, reset, !accept, !rsp_strobe, "result without a request")

endmodule
